// ===== rtl/ckv_pkg.sv =====
// Shared types, constants and functions of the checkpoint frame verifier.
package ckv_pkg;

    // Parser phases of the front part.
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_HEADER  = 3'd1,
        PH_NAME    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // Verdict codes as they appear on the result port.
    typedef enum logic [2:0] {
        V_OK           = 3'd0,
        V_BAD_MAGIC    = 3'd1,
        V_SHORT_HEADER = 3'd2,
        V_BAD_VERSION  = 3'd3,
        V_TRUNCATED    = 3'd4,
        V_CRC_MISMATCH = 3'd5
    } t_verdict;

    // Kind of a result word.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    // Command passed from the front part to the back part. A command holds an
    // optional payload byte followed by an optional verdict; at least one is set.
    typedef struct packed {
        logic        has_pay;
        logic [7:0]  pay_byte;
        logic        has_verd;
        logic        verd_crc;   // Verdict comes from the CRC comparison.
        t_verdict    verd_code;  // Fixed verdict when verd_crc is low.
        logic [31:0] exp_crc;
    } t_cmd;

    // Command queue geometry.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Header layout, byte offsets after the magic.
    localparam int          IDX_W        = 5;
    localparam logic [4:0]  MAGIC_LAST   = 5'd3;
    localparam logic [4:0]  HDR_VER_END  = 5'd2;
    localparam logic [4:0]  HDR_NAME_END = 5'd4;
    localparam logic [4:0]  HDR_TS_END   = 5'd12;
    localparam logic [4:0]  HDR_CRC_END  = 5'd16;
    localparam logic [4:0]  HDR_LAST     = 5'd23;
    localparam logic [15:0] VERSION_ONE  = 16'd1;

    // CRC-32 constants, reflected IEEE polynomial.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;

    // Expected magic byte at a given position of the string "CKPT".
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        unique case (pos)
            2'd0: m = 8'h43;
            2'd1: m = 8'h4B;
            2'd2: m = 8'h50;
            default: m = 8'h54;
        endcase
        return m;
    endfunction

    // One byte step of the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/checkpoint_frame_verifier_unit.sv =====
// Top level of the checkpoint frame verifier.
//
//  Channel  | Handshake          | Words
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | file_byte, byte_valid, end_of_file
//  result   | empty / pop        | result_kind, payload_byte, verdict, last
//
// One input word is taken per cycle while the four-entry command queue has room.
// Each input word yields up to two result words (payload byte, then verdict); the
// back part emits one result word per cycle unless its result word waits for pop.
// Result words are registered from the head command into a register on the ports.
// Reset is synchronous and active low and leaves both queues empty.
// A stalled result side fills the command queue, after which full rises.
module checkpoint_frame_verifier_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_file_byte,
    input  logic       i_byte_valid,
    input  logic       i_end_of_file,
    output logic       empty,
    input  logic       pop,
    output logic       o_result_kind,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_verdict,
    output logic       o_last
);
    import ckv_pkg::*;

    logic w_cmd_push;
    t_cmd w_cmd_in;
    logic w_cmd_empty;
    t_cmd w_cmd_out;
    logic w_cmd_pop;

    // Parser and classifier.
    ckv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_file_byte   (i_file_byte),
        .i_byte_valid  (i_byte_valid),
        .i_end_of_file (i_end_of_file),
        .o_cmd_push    (w_cmd_push),
        .o_cmd         (w_cmd_in)
    );

    // Command queue.
    ckv_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    // CRC and result stage.
    ckv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!w_cmd_empty),
        .i_cmd          (w_cmd_out),
        .o_cmd_pop      (w_cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_verdict      (o_verdict),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/ckv_front.sv =====
// Front part: parses the file stream and turns each word that yields a payload byte or a verdict into a command.
module ckv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  logic [7:0]    i_file_byte,
    input  logic          i_byte_valid,
    input  logic          i_end_of_file,
    output logic          o_cmd_push,
    output ckv_pkg::t_cmd o_cmd
);
    import ckv_pkg::*;

    t_phase             r_phase, n_phase, s_phase;
    logic [IDX_W-1:0]   r_idx, n_idx, s_idx;
    logic [15:0]        r_ver, n_ver, s_ver;
    logic [15:0]        r_name, n_name, s_name;
    logic [31:0]        r_exp, n_exp, s_exp;
    logic [63:0]        r_pay, n_pay, s_pay;
    logic               w_take;
    logic               w_byte;
    logic               w_eof;
    logic               w_magic_ok;
    t_cmd               w_cmd;

    // A pushed word is taken whenever the command queue has room.
    assign w_take     = i_push && !i_full;
    assign w_byte     = w_take && i_byte_valid;
    assign w_eof      = w_take && i_end_of_file;
    assign w_magic_ok = (i_file_byte == magic_byte(r_idx[1:0]));

    // State after the byte of this word has been parsed.
    always_comb begin
        s_phase = r_phase;
        s_idx   = r_idx;
        s_ver   = r_ver;
        s_name  = r_name;
        s_exp   = r_exp;
        s_pay   = r_pay;
        if (w_byte) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (!w_magic_ok) begin
                        s_phase = PH_DONE;
                    end else if (r_idx == MAGIC_LAST) begin
                        s_idx   = '0;
                        s_phase = PH_HEADER;
                    end else begin
                        s_idx = r_idx + IDX_W'(1);
                    end
                end
                PH_HEADER: begin
                    if (r_idx < HDR_VER_END) begin
                        s_ver[{r_idx[0], 3'b000} +: 8] = i_file_byte;
                    end else if (r_idx < HDR_NAME_END) begin
                        s_name[{r_idx[0], 3'b000} +: 8] = i_file_byte;
                    end else if (r_idx < HDR_TS_END) begin
                        s_ver = r_ver;  // Timestamp bytes are skipped.
                    end else if (r_idx < HDR_CRC_END) begin
                        s_exp[{r_idx[1:0], 3'b000} +: 8] = i_file_byte;
                    end else begin
                        s_pay[{r_idx[2:0], 3'b000} +: 8] = i_file_byte;
                    end
                    if (r_idx == HDR_LAST) begin
                        s_idx = '0;
                        if (s_ver != VERSION_ONE) begin
                            s_phase = PH_DONE;
                        end else if (s_name != '0) begin
                            s_phase = PH_NAME;
                        end else if (s_pay != '0) begin
                            s_phase = PH_PAYLOAD;
                        end else begin
                            s_phase = PH_DONE;
                        end
                    end else begin
                        s_idx = r_idx + IDX_W'(1);
                    end
                end
                PH_NAME: begin
                    s_name = r_name - 16'd1;
                    if (s_name == '0) begin
                        s_phase = (r_pay != '0) ? PH_PAYLOAD : PH_DONE;
                    end
                end
                PH_PAYLOAD: begin
                    s_pay = r_pay - 64'd1;
                    if (s_pay == '0) begin
                        s_phase = PH_DONE;
                    end
                end
                default: begin
                    s_phase = r_phase;
                end
            endcase
        end
    end

    // Next state: end of file returns the parser to its reset state.
    always_comb begin
        if (w_eof) begin
            n_phase = PH_MAGIC;
            n_idx   = '0;
            n_ver   = '0;
            n_name  = '0;
            n_exp   = '0;
            n_pay   = '0;
        end else begin
            n_phase = s_phase;
            n_idx   = s_idx;
            n_ver   = s_ver;
            n_name  = s_name;
            n_exp   = s_exp;
            n_pay   = s_pay;
        end
    end

    // Command for the back part: a payload byte and/or a verdict.
    always_comb begin
        w_cmd          = '0;
        w_cmd.exp_crc  = s_exp;
        w_cmd.pay_byte = i_file_byte;
        if (w_byte) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (!w_magic_ok) begin
                        w_cmd.has_verd  = 1'b1;
                        w_cmd.verd_code = V_BAD_MAGIC;
                    end
                end
                PH_HEADER: begin
                    if (r_idx == HDR_LAST) begin
                        if (s_ver != VERSION_ONE) begin
                            w_cmd.has_verd  = 1'b1;
                            w_cmd.verd_code = V_BAD_VERSION;
                        end else if (s_name == '0 && s_pay == '0) begin
                            w_cmd.has_verd = 1'b1;
                            w_cmd.verd_crc = 1'b1;
                        end
                    end
                end
                PH_NAME: begin
                    if (s_name == '0 && r_pay == '0) begin
                        w_cmd.has_verd = 1'b1;
                        w_cmd.verd_crc = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    w_cmd.has_pay = 1'b1;
                    if (s_pay == '0) begin
                        w_cmd.has_verd = 1'b1;
                        w_cmd.verd_crc = 1'b1;
                    end
                end
                default: begin
                    w_cmd.has_pay = 1'b0;
                end
            endcase
        end
        // End of file forces a verdict unless one has been given already.
        if (w_eof && s_phase != PH_DONE) begin
            w_cmd.has_verd = 1'b1;
            unique case (s_phase)
                PH_MAGIC:   w_cmd.verd_code = V_BAD_MAGIC;
                PH_HEADER:  w_cmd.verd_code = V_SHORT_HEADER;
                PH_NAME: begin
                    if (s_pay != '0) begin
                        w_cmd.verd_code = V_TRUNCATED;
                    end else begin
                        w_cmd.verd_crc = 1'b1;
                    end
                end
                default:    w_cmd.verd_code = V_TRUNCATED;
            endcase
        end
    end

    assign o_cmd      = w_cmd;
    assign o_cmd_push = w_take && (w_cmd.has_pay || w_cmd.has_verd);

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_idx   <= '0;
            r_ver   <= '0;
            r_name  <= '0;
            r_exp   <= '0;
            r_pay   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_ver   <= n_ver;
            r_name  <= n_name;
            r_exp   <= n_exp;
            r_pay   <= n_pay;
        end
    end

endmodule

// ===== rtl/ckv_cmd_fifo.sv =====
// Short command queue between the front and the back part.
module ckv_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ckv_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ckv_pkg::t_cmd o_cmd
);
    import ckv_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + CMD_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + CMD_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + CMD_CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/ckv_back.sv =====
// Back part: runs the CRC, resolves verdicts and holds the result register.
module ckv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ckv_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_result_kind,
    output logic [7:0]    o_payload_byte,
    output logic [2:0]    o_verdict,
    output logic          o_last
);
    import ckv_pkg::*;

    logic        r_valid, n_valid;
    logic        r_half, n_half;
    logic [31:0] r_crc, n_crc;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    t_verdict    r_verdict, n_verdict;
    logic        r_last, n_last;
    logic        w_load;

    // The result register loads when it is free or being drained.
    assign w_load = !r_valid || i_pop;

    // Command execution: a payload byte first, then the verdict of the same command.
    always_comb begin
        o_cmd_pop = 1'b0;
        n_valid   = r_valid && !i_pop;
        n_half    = r_half;
        n_crc     = r_crc;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_verdict = r_verdict;
        n_last    = r_last;
        if (w_load && i_cmd_valid) begin
            n_valid = 1'b1;
            if (i_cmd.has_pay && !r_half) begin
                n_kind    = KIND_PAYLOAD;
                n_byte    = i_cmd.pay_byte;
                n_verdict = V_OK;
                n_last    = 1'b0;
                n_crc     = crc_byte(r_crc, i_cmd.pay_byte);
                if (i_cmd.has_verd) begin
                    n_half = 1'b1;
                end else begin
                    o_cmd_pop = 1'b1;
                end
            end else begin
                n_kind = KIND_VERDICT;
                n_byte = '0;
                n_last = 1'b1;
                if (i_cmd.verd_crc) begin
                    n_verdict = ((r_crc ^ CRC_XOR) == i_cmd.exp_crc) ? V_OK : V_CRC_MISMATCH;
                end else begin
                    n_verdict = i_cmd.verd_code;
                end
                // A verdict closes the file, so the CRC starts over.
                n_crc     = CRC_INIT;
                n_half    = 1'b0;
                o_cmd_pop = 1'b1;
            end
        end
    end

    // Control and CRC registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
            r_crc   <= CRC_INIT;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
            r_crc   <= n_crc;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_byte    <= n_byte;
        r_verdict <= n_verdict;
        r_last    <= n_last;
    end

    assign o_empty        = !r_valid;
    assign o_result_kind  = r_kind;
    assign o_payload_byte = r_byte;
    assign o_verdict      = r_verdict;
    assign o_last         = r_last;

endmodule
